// ----- sv/hfd_pkg.sv -----
// hfd_pkg: types, result codes and phase codes of the Huffman frame decoder.
// No dependencies; imported by hfd_out_stage and huffman_frame_decoder.
`default_nettype none
package hfd_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 32;

    // result codes
    localparam logic [2:0] OC_SYMBOL   = 3'd0;
    localparam logic [2:0] OC_COMPLETE = 3'd1;
    localparam logic [2:0] OC_EMPTY    = 3'd2;
    localparam logic [2:0] OC_DISCARD  = 3'd3;
    localparam logic [2:0] OC_TOOMANY  = 3'd4;

    // frame phases
    localparam logic [2:0] PH_LENGTH  = 3'd0;
    localparam logic [2:0] PH_COUNT   = 3'd1;
    localparam logic [2:0] PH_ENTRIES = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_EMPTY   = 3'd4;
    localparam logic [2:0] PH_TOOMANY = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic [2:0] outcome;
        logic       last_of_run;
    } t_out;

    // request from the sequencer to the output stage
    typedef struct packed {
        logic produce;
        logic flush;
        t_out item;
    } t_emit;

endpackage
`default_nettype wire

// ----- sv/hfd_out_stage.sv -----
// hfd_out_stage: holds one result back so the final result of a byte can be
// marked last_of_run, then drives the strobed result register. Uses hfd_pkg.
`default_nettype none
module hfd_out_stage
    import hfd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_emit i_emit,
    output logic       o_strobe,
    output t_out       o_out
);

    logic r_pv;
    t_out r_pend;
    logic r_out_v;
    t_out r_out;

    // pending result leaves when a newer one arrives (not last) or on flush (last)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_emit.flush) begin
            r_out_v <= r_pv;
            r_pv    <= 1'b0;
        end else if (i_emit.produce) begin
            r_out_v <= r_pv;
            r_pv    <= 1'b1;
        end else begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.flush) begin
            r_out             <= r_pend;
            r_out.last_of_run <= 1'b1;
        end else if (i_emit.produce) begin
            r_out             <= r_pend;
            r_out.last_of_run <= 1'b0;
            r_pend            <= i_emit.item;
        end
    end

    assign o_strobe = r_out_v;
    assign o_out    = r_out;

endmodule
`default_nettype wire

// ----- sv/huffman_frame_decoder.sv -----
// huffman_frame_decoder: static-frequency Huffman frame decoder, top level.
// Depends on hfd_pkg and hfd_out_stage.
//
//  channel  ports                      transfer
//  input    i_start, o_busy, i_in      edge with i_start high and o_busy low
//  result   o_strobe, o_out            every edge that ends a strobe cycle
//
// A header byte passes through decode, status and flush. A code byte takes an
// S_WRD and an S_WDAT step per internal node and an added S_LEAF step per leaf
// (registered node memory read), plus decode, end check, status and flush; with a
// single symbol each bit is handled in S_WRD alone. The walk ends early once the length is reached.
// After the last entry the list fill writes the m leaf indexes, and the tree build
// scans the whole active list for each pop, for m entries.
// Reset is synchronous; memories need no clearing. Results cannot be stalled.
`default_nettype none
module huffman_frame_decoder
    import hfd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_in,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out      o_out
);

    localparam int NODE_DEPTH = 2 * MAX_SYMBOLS;
    localparam int NW = $clog2(NODE_DEPTH);
    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    typedef struct packed {
        logic [7:0]             sym;
        logic [WEIGHT_BITS-1:0] w;
        logic [NW-1:0]          l;
        logic [NW-1:0]          r;
    } t_node;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROC  = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_SRA   = 4'd3;
    localparam logic [3:0] S_SRW   = 4'd4;
    localparam logic [3:0] S_SCMP  = 4'd5;
    localparam logic [3:0] S_POPW  = 4'd6;
    localparam logic [3:0] S_MERGE = 4'd7;
    localparam logic [3:0] S_WRD   = 4'd8;
    localparam logic [3:0] S_WDAT  = 4'd9;
    localparam logic [3:0] S_LEAF  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_FLUSH = 4'd12;

    // memories
    t_node         node_mem [NODE_DEPTH];
    logic [NW-1:0] act_mem  [MAX_SYMBOLS];
    t_node         node_rd;
    logic [NW-1:0] act_rd;

    logic          node_we, act_we;
    logic [NW-1:0] node_waddr, node_raddr, act_wdata;
    logic [AW-1:0] act_waddr, act_raddr;
    t_node         node_wdata;

    // control registers
    logic [3:0]             r_st;
    logic [2:0]             r_phase;
    logic [2:0]             r_hp;
    logic [31:0]            r_wa;
    logic [LENGTH_BITS-1:0] r_len, r_emit;
    logic [15:0]            r_count;
    logic [CW-1:0]          r_loaded, r_i, r_size, r_best_i;
    logic [NW-1:0]          r_pool, r_root, r_walk;
    logic [7:0]             r_d, r_esym, r_sym0;
    logic                   r_eof, r_second;
    logic [3:0]             r_nleft;
    logic [NW-1:0]          r_cand, r_last, r_bn, r_an;
    logic [WEIGHT_BITS-1:0] r_bw, r_aw;
    logic [7:0]             r_bs, r_as;

    t_emit                  emit;
    logic [31:0]            wa_n;
    logic [NW-1:0]          child;
    logic                   better;
    logic [2:0]             status;

    // byte merged into the word under assembly
    always_comb begin
        logic [1:0] pos;
        pos = (r_phase == PH_ENTRIES) ? 2'(r_hp - 3'd1) : r_hp[1:0];
        wa_n = r_wa | ({24'b0, r_d} << {pos, 3'b000});
    end

    assign child  = r_d[7] ? node_rd.r : node_rd.l;
    assign better = (r_i == '0) || (node_rd.w < r_bw) ||
                    ((node_rd.w == r_bw) && (r_cand < r_bn));

    always_comb begin
        if (r_phase == PH_TOOMANY)                     status = OC_TOOMANY;
        else if (r_phase != PH_DATA || r_emit == '0)   status = OC_EMPTY;
        else if (r_emit == r_len)                      status = OC_COMPLETE;
        else                                           status = OC_DISCARD;
    end

    // memory access steering and result requests
    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_pool;
        node_wdata = '{sym: (r_as < r_bs) ? r_as : r_bs, w: r_aw + r_bw,
                       l: r_an, r: r_bn};
        node_raddr = r_walk;
        act_we     = 1'b0;
        act_waddr  = r_i[AW-1:0];
        act_wdata  = NW'(r_i);
        act_raddr  = r_i[AW-1:0];
        emit       = '{produce: 1'b0, flush: 1'b0,
                       item: '{out_symbol: 8'd0, outcome: OC_SYMBOL, last_of_run: 1'b0}};
        case (r_st)
            S_PROC: begin
                if (r_phase == PH_ENTRIES && r_hp == 3'd4) begin
                    node_we    = 1'b1;
                    node_waddr = NW'(r_loaded);
                    node_wdata = '{sym: r_esym, w: wa_n[WEIGHT_BITS-1:0], l: '0, r: '0};
                end
            end
            S_INIT: act_we = 1'b1;
            S_SRW:  node_raddr = act_rd;
            S_POPW: begin
                act_we    = 1'b1;
                act_waddr = r_best_i[AW-1:0];
                act_wdata = r_last;
            end
            S_MERGE: begin
                node_we   = 1'b1;
                act_we    = 1'b1;
                act_waddr = r_size[AW-1:0];
                act_wdata = r_pool;
            end
            S_WRD: begin
                if (r_nleft != 4'd0 && r_emit != r_len && r_count == 16'd1) begin
                    emit.produce         = 1'b1;
                    emit.item.out_symbol = r_sym0;
                end
            end
            S_WDAT: node_raddr = child;
            S_LEAF: begin
                emit.produce         = 1'b1;
                emit.item.out_symbol = node_rd.sym;
            end
            S_FIN: begin
                if (r_eof) begin
                    emit.produce      = 1'b1;
                    emit.item.outcome = status;
                end
            end
            S_FLUSH: emit.flush = 1'b1;
            default: ;
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (node_we) node_mem[node_waddr] <= node_wdata;
        node_rd <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (act_we) act_mem[act_waddr] <= act_wdata;
        act_rd <= act_mem[act_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_phase  <= PH_LENGTH;
            r_hp     <= '0;
            r_wa     <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_loaded <= '0;
            r_size   <= '0;
            r_pool   <= '0;
            r_root   <= '0;
            r_walk   <= '0;
            r_emit   <= '0;
            r_second <= 1'b0;
            r_i      <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_d   <= i_in.data_byte;
                        r_eof <= i_in.end_of_frame;
                        r_st  <= S_PROC;
                    end
                end
                S_PROC: begin
                    r_st <= S_FIN;
                    case (r_phase)
                        PH_LENGTH: begin
                            r_wa <= wa_n;
                            r_hp <= r_hp + 3'd1;
                            if (r_hp == 3'd3) begin
                                r_len   <= wa_n[LENGTH_BITS-1:0];
                                r_wa    <= '0;
                                r_hp    <= '0;
                                r_phase <= (wa_n[LENGTH_BITS-1:0] == '0) ? PH_EMPTY : PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            r_wa <= wa_n;
                            r_hp <= r_hp + 3'd1;
                            if (r_hp == 3'd1) begin
                                r_count  <= wa_n[15:0];
                                r_wa     <= '0;
                                r_hp     <= '0;
                                r_loaded <= '0;
                                if (wa_n[15:0] == 16'd0)
                                    r_phase <= PH_EMPTY;
                                else if (wa_n[15:0] > 16'(MAX_SYMBOLS))
                                    r_phase <= PH_TOOMANY;
                                else
                                    r_phase <= PH_ENTRIES;
                            end
                        end
                        PH_ENTRIES: begin
                            r_hp <= r_hp + 3'd1;
                            if (r_hp == 3'd0) begin
                                r_esym <= r_d;
                                r_wa   <= '0;
                            end else begin
                                r_wa <= wa_n;
                            end
                            if (r_hp == 3'd4) begin
                                r_wa     <= '0;
                                r_hp     <= '0;
                                r_loaded <= r_loaded + 1'b1;
                                if (r_loaded == '0) r_sym0 <= r_esym;
                                if (16'(r_loaded) + 16'd1 >= r_count) begin
                                    r_phase <= PH_DATA;
                                    r_i     <= '0;
                                    if (!r_eof) r_st <= S_INIT;
                                end
                            end
                        end
                        PH_DATA: begin
                            r_nleft <= 4'd8;
                            r_st    <= S_WRD;
                        end
                        default: ;
                    endcase
                end
                // fill the active list with the leaf indexes
                S_INIT: begin
                    if (r_count == 16'd1) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (16'(r_i) + 16'd1 == r_count) begin
                            r_size   <= CW'(r_count);
                            r_pool   <= NW'(r_count);
                            r_i      <= '0;
                            r_second <= 1'b0;
                            r_st     <= S_SRA;
                        end
                    end
                end
                // least-node scan, one element per pass through S_SRA, S_SRW and S_SCMP
                S_SRA: r_st <= S_SRW;
                S_SRW: begin
                    r_cand <= act_rd;
                    if (r_i + 1'b1 == r_size) r_last <= act_rd;
                    r_st <= S_SCMP;
                end
                S_SCMP: begin
                    if (better) begin
                        r_best_i <= r_i;
                        r_bn     <= r_cand;
                        r_bw     <= node_rd.w;
                        r_bs     <= node_rd.sym;
                    end
                    r_i  <= r_i + 1'b1;
                    r_st <= (r_i + 1'b1 == r_size) ? S_POPW : S_SRA;
                end
                S_POPW: begin
                    r_size <= r_size - 1'b1;
                    if (!r_second) begin
                        r_an     <= r_bn;
                        r_aw     <= r_bw;
                        r_as     <= r_bs;
                        r_second <= 1'b1;
                        r_i      <= '0;
                        r_st     <= S_SRA;
                    end else begin
                        r_st <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    r_size   <= r_size + 1'b1;
                    r_pool   <= r_pool + 1'b1;
                    r_second <= 1'b0;
                    r_i      <= '0;
                    if (r_size == '0) begin
                        r_root <= r_pool;
                        r_walk <= r_pool;
                        r_st   <= S_IDLE;
                    end else begin
                        r_st <= S_SRA;
                    end
                end
                // tree walk, MSB first
                S_WRD: begin
                    if (r_nleft == 4'd0 || r_emit == r_len) begin
                        r_st <= S_FIN;
                    end else if (r_count == 16'd1) begin
                        r_emit  <= r_emit + 1'b1;
                        r_nleft <= r_nleft - 4'd1;
                        r_d     <= {r_d[6:0], 1'b0};
                    end else begin
                        r_st <= S_WDAT;
                    end
                end
                S_WDAT: begin
                    r_nleft <= r_nleft - 4'd1;
                    r_d     <= {r_d[6:0], 1'b0};
                    if (16'(child) < r_count) begin
                        r_st <= S_LEAF;
                    end else begin
                        r_walk <= child;
                        r_st   <= S_WRD;
                    end
                end
                S_LEAF: begin
                    r_emit <= r_emit + 1'b1;
                    r_walk <= r_root;
                    r_st   <= S_WRD;
                end
                // final status and frame clear
                S_FIN: begin
                    if (r_eof) begin
                        r_phase  <= PH_LENGTH;
                        r_hp     <= '0;
                        r_wa     <= '0;
                        r_len    <= '0;
                        r_count  <= '0;
                        r_loaded <= '0;
                        r_size   <= '0;
                        r_pool   <= '0;
                        r_root   <= '0;
                        r_walk   <= '0;
                        r_emit   <= '0;
                    end
                    r_st <= S_FLUSH;
                end
                S_FLUSH: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != S_IDLE);

    hfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    // checks
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after input transfer");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.outcome != OC_SYMBOL) |-> o_out.last_of_run)
        else $error("status result not marked last");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit <= r_len))
        else $error("emitted count passed original length");
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size <= CW'(MAX_SYMBOLS)))
        else $error("active list overflow");

endmodule
`default_nettype wire
